FILE: sv/mbrh_pkg.sv
// ----------------------------------------------------------------------------
// mbrh_pkg
// Shared types, constants and the CRC-16 byte update for the Modbus RTU
// function 03 master.
// ----------------------------------------------------------------------------
package mbrh_pkg;

   localparam int          MAX_REGISTERS_DEF = 125;
   localparam logic [7:0]  FC_READ           = 8'h03;
   localparam int          EXC_FLAG_BIT      = 7;
   localparam logic [7:0]  MAX_SLAVE         = 8'd247;
   localparam logic [15:0] CRC_INIT          = 16'hFFFF;
   localparam logic [15:0] CRC_POLY          = 16'hA001;
   localparam logic [15:0] TIMEOUT_RESET     = 16'd500;

   typedef enum logic [1:0] {
      FUNC_START = 2'd0,
      FUNC_BYTE  = 2'd1,
      FUNC_TICK  = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      KIND_TX     = 2'd0,
      KIND_WORD   = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_NO_RESPONSE = 3'd1,
      ST_SHORT_FRAME = 3'd2,
      ST_EXCEPTION   = 3'd3,
      ST_CRC_ERROR   = 3'd4,
      ST_MALFORMED   = 3'd5,
      ST_INVALID_ARG = 3'd6
   } status_type;

   // position of a byte within the outgoing request
   typedef enum logic [2:0] {
      RB_ADDR     = 3'd0,
      RB_FUNC     = 3'd1,
      RB_FIRST_HI = 3'd2,
      RB_FIRST_LO = 3'd3,
      RB_COUNT_HI = 3'd4,
      RB_COUNT_LO = 3'd5,
      RB_CRC_LO   = 3'd6,
      RB_CRC_HI   = 3'd7
   } req_byte_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  slave_address;
      logic [15:0] first_register;
      logic [15:0] register_count;
      logic [7:0]  rx_data;
   } item_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  tx_data;
      logic [15:0] register_word;
      logic [6:0]  register_index;
      status_type  status;
      logic [7:0]  exception_code;
      logic        last;
   } rsp_type;

   // deframer result for one processed item
   typedef struct packed {
      logic    emit;
      logic    launch;
      rsp_type rsp;
   } core_res_type;

   // request byte offered by the sequencer
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
   } tx_word_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: sv/modbus_rtu_read_holding_master.sv
// ----------------------------------------------------------------------------
// modbus_rtu_read_holding_master
// Modbus RTU function 03 master: request framing, reply deframing, timeout.
// ----------------------------------------------------------------------------
// Bytes and ticks are taken one per cycle while no request burst or stalled
// result holds them; a word is registered when it is accepted and, once the
// core takes it, its result loads into the result register.
// A valid start launches the request sequencer, which puts out the eight
// request bytes at one per cycle while results are not stalled, computing
// the CRC a byte at a time as they leave; the input side stalls until the
// burst has drained, and longer while results stall.
// Register words stream out as they complete and must be discarded unless
// the final status word is ok. No memories, no clearing pass after reset.
module modbus_rtu_read_holding_master #(
   parameter int MAX_REGISTERS = mbrh_pkg::MAX_REGISTERS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_slave_address,
   input  logic [15:0] req_first_register,
   input  logic [15:0] req_register_count,
   input  logic [7:0]  req_rx_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_tx_data,
   output logic [15:0] rsp_register_word,
   output logic [6:0]  rsp_register_index,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_exception_code,
   output logic        rsp_last
);

   mbrh_pkg::item_type     req_item;
   mbrh_pkg::item_type     item;
   logic                   item_valid;
   logic                   take;
   logic                   slot_free;
   logic                   advance;
   mbrh_pkg::core_res_type core_res;
   mbrh_pkg::tx_word_type  tx;
   logic                   rsp_valid_ff, rsp_valid_in;
   mbrh_pkg::rsp_type      rsp_ff, rsp_in;

   assign req_item.func           = req_func;
   assign req_item.slave_address  = req_slave_address;
   assign req_item.first_register = req_first_register;
   assign req_item.register_count = req_register_count;
   assign req_item.rx_data        = req_rx_data;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   // request bytes go first; the core waits for the burst to drain
   assign take      = item_valid && slot_free && !tx.valid;
   assign advance   = tx.valid && slot_free;

   mbrh_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   mbrh_deframer #(
      .MAX_REGISTERS (MAX_REGISTERS)
   ) u_deframer (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .take        (take),
      .item        (item),
      .res         (core_res)
   );

   mbrh_req_gen u_req_gen (
      .clock          (clock),
      .reset          (reset),
      .launch         (core_res.launch),
      .slave_address  (item.slave_address),
      .first_register (item.first_register),
      .register_count (item.register_count),
      .advance        (advance),
      .tx             (tx)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in   = 1'b1;
         rsp_in         = '0;
         rsp_in.kind    = mbrh_pkg::KIND_TX;
         rsp_in.tx_data = tx.data;
         rsp_in.last    = tx.last;
      end else if (take && core_res.emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = core_res.rsp;
      end else if (slot_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_ff.kind;
   assign rsp_tx_data        = rsp_ff.tx_data;
   assign rsp_register_word  = rsp_ff.register_word;
   assign rsp_register_index = rsp_ff.register_index;
   assign rsp_status         = rsp_ff.status;
   assign rsp_exception_code = rsp_ff.exception_code;
   assign rsp_last           = rsp_ff.last;

`ifndef SYNTHESIS
   // the core never consumes a word while a request burst is draining
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(tx.valid && take))
      else $error("item taken during request burst");

   // a launch is always followed by the first request byte
   a_launch_tx: assert property (@(posedge clock) disable iff (reset)
      take && core_res.launch |=> tx.valid && tx.data == $past(item.slave_address))
      else $error("request burst did not start after launch");

   // status words always close a burst
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == mbrh_pkg::KIND_STATUS |-> rsp_last)
      else $error("status word without last");
`endif

endmodule

FILE: sv/mbrh_in_reg.sv
// ----------------------------------------------------------------------------
// mbrh_in_reg
// Input register: holds one request word until the core takes it.
// ----------------------------------------------------------------------------
module mbrh_in_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  mbrh_pkg::item_type req_item,
   input  logic               take,
   output logic               item_valid,
   output mbrh_pkg::item_type item
);

   logic               valid_ff, valid_in;
   mbrh_pkg::item_type item_ff;
   logic               accept;

   assign req_stall  = valid_ff && !take;
   assign accept     = req_valid && !req_stall;
   assign valid_in   = accept || (valid_ff && !take);
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

endmodule

FILE: sv/mbrh_req_gen.sv
// ----------------------------------------------------------------------------
// mbrh_req_gen
// Request sequencer: sends the eight request bytes one per cycle while
// advance is asserted and folds each header byte into the CRC as it goes out.
// ----------------------------------------------------------------------------
module mbrh_req_gen (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  launch,
   input  logic [7:0]            slave_address,
   input  logic [15:0]           first_register,
   input  logic [15:0]           register_count,
   input  logic                  advance,
   output mbrh_pkg::tx_word_type tx
);

   logic                   active_ff, active_in;
   mbrh_pkg::req_byte_type idx_ff, idx_in;
   logic [7:0]             addr_ff;
   logic [15:0]            first_ff;
   logic [15:0]            count_ff;
   logic [15:0]            crc_ff, crc_in;
   logic [7:0]             cur_byte;

   always_comb begin
      case (idx_ff)
         mbrh_pkg::RB_ADDR:     cur_byte = addr_ff;
         mbrh_pkg::RB_FUNC:     cur_byte = mbrh_pkg::FC_READ;
         mbrh_pkg::RB_FIRST_HI: cur_byte = first_ff[15:8];
         mbrh_pkg::RB_FIRST_LO: cur_byte = first_ff[7:0];
         mbrh_pkg::RB_COUNT_HI: cur_byte = count_ff[15:8];
         mbrh_pkg::RB_COUNT_LO: cur_byte = count_ff[7:0];
         mbrh_pkg::RB_CRC_LO:   cur_byte = crc_ff[7:0];
         mbrh_pkg::RB_CRC_HI:   cur_byte = crc_ff[15:8];
         default:               cur_byte = 8'h00;
      endcase
   end

   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      crc_in    = crc_ff;
      if (launch) begin
         active_in = 1'b1;
         idx_in    = mbrh_pkg::RB_ADDR;
         crc_in    = mbrh_pkg::CRC_INIT;
      end else if (active_ff && advance) begin
         idx_in = mbrh_pkg::req_byte_type'(idx_ff + 3'd1);
         if (idx_ff < mbrh_pkg::RB_CRC_LO) begin
            crc_in = mbrh_pkg::crc_byte(crc_ff, cur_byte);
         end
         if (idx_ff == mbrh_pkg::RB_CRC_HI) begin
            active_in = 1'b0;
         end
      end
   end

   assign tx.valid = active_ff;
   assign tx.data  = cur_byte;
   assign tx.last  = (idx_ff == mbrh_pkg::RB_CRC_HI);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= mbrh_pkg::RB_ADDR;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
      if (launch) begin
         addr_ff  <= slave_address;
         first_ff <= first_register;
         count_ff <= register_count;
      end
   end

`ifndef SYNTHESIS
   // a burst only ends after its final CRC byte went out
   a_burst_end: assert property (@(posedge clock) disable iff (reset)
      $fell(active_ff) |-> $past(idx_ff) == mbrh_pkg::RB_CRC_HI)
      else $error("request burst ended early");
`endif

endmodule

FILE: sv/mbrh_deframer.sv
// ----------------------------------------------------------------------------
// mbrh_deframer
// Transaction state: start checks, reply deframing, CRC check and the
// response timeout.
// ----------------------------------------------------------------------------
module mbrh_deframer #(
   parameter int MAX_REGISTERS = mbrh_pkg::MAX_REGISTERS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [15:0]            csr_wr_data,
   input  logic                   take,
   input  mbrh_pkg::item_type     item,
   output mbrh_pkg::core_res_type res
);

   localparam int CNT_W = $clog2(MAX_REGISTERS + 1);
   localparam int POS_W = $clog2(2 * MAX_REGISTERS + 6);

   logic [15:0]      timeout_ff;
   logic             awaiting_ff, awaiting_in;
   logic [7:0]       target_ff, target_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       raddr_ff, raddr_in;
   logic [7:0]       rfunc_ff, rfunc_in;
   logic [7:0]       rbc_ff, rbc_in;
   logic [7:0]       held_ff, held_in;
   logic [15:0]      ticks_ff, ticks_in;
   logic [7:0]       exc_ff, exc_in;

   logic [POS_W-1:0] data_end;
   logic [POS_W-1:0] pos_off;
   logic [15:0]      crc_upd;
   logic [15:0]      got_crc;
   logic             start_bad;
   logic [7:0]       b;

   assign b         = item.rx_data;
   assign data_end  = POS_W'(2 * int'(count_ff) + 3);
   assign pos_off   = pos_ff - POS_W'(3);
   assign crc_upd   = mbrh_pkg::crc_byte(crc_ff, b);
   assign got_crc   = {b, held_ff};
   assign start_bad = (item.register_count == 16'd0)
                   || (item.register_count > 16'(MAX_REGISTERS))
                   || (item.slave_address == 8'd0)
                   || (item.slave_address > mbrh_pkg::MAX_SLAVE);

   always_comb begin
      awaiting_in = awaiting_ff;
      target_in   = target_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      crc_in      = crc_ff;
      raddr_in    = raddr_ff;
      rfunc_in    = rfunc_ff;
      rbc_in      = rbc_ff;
      held_in     = held_ff;
      ticks_in    = ticks_ff;
      exc_in      = exc_ff;
      res         = '0;

      if (take) begin
         case (item.func)
            mbrh_pkg::FUNC_START: begin
               if (start_bad) begin
                  res.emit       = 1'b1;
                  res.rsp.kind   = mbrh_pkg::KIND_STATUS;
                  res.rsp.status = mbrh_pkg::ST_INVALID_ARG;
               end else begin
                  res.launch  = 1'b1;
                  exc_in      = 8'h00;
                  awaiting_in = 1'b1;
                  target_in   = item.slave_address;
                  count_in    = CNT_W'(item.register_count);
                  pos_in      = '0;
                  crc_in      = mbrh_pkg::CRC_INIT;
                  raddr_in    = 8'h00;
                  rfunc_in    = 8'h00;
                  rbc_in      = 8'h00;
                  held_in     = 8'h00;
                  ticks_in    = (timeout_ff == 16'd0) ? 16'd1 : timeout_ff;
               end
            end
            mbrh_pkg::FUNC_BYTE: begin
               if (awaiting_ff) begin
                  if (pos_ff < POS_W'(2)) begin
                     if (pos_ff == '0) begin
                        raddr_in = b;
                     end else begin
                        rfunc_in = b;
                     end
                     crc_in = crc_upd;
                     pos_in = pos_ff + POS_W'(1);
                  end else if (rfunc_ff[mbrh_pkg::EXC_FLAG_BIT]) begin
                     // exception reply: address, function, code, CRC
                     if (pos_ff == POS_W'(2)) begin
                        rbc_in = b;
                        crc_in = crc_upd;
                        pos_in = pos_ff + POS_W'(1);
                     end else if (pos_ff == POS_W'(3)) begin
                        held_in = b;
                        pos_in  = pos_ff + POS_W'(1);
                     end else begin
                        awaiting_in  = 1'b0;
                        res.emit     = 1'b1;
                        res.rsp.kind = mbrh_pkg::KIND_STATUS;
                        if (got_crc != crc_ff) begin
                           res.rsp.status = mbrh_pkg::ST_CRC_ERROR;
                        end else begin
                           exc_in         = rbc_ff;
                           res.rsp.status = mbrh_pkg::ST_EXCEPTION;
                        end
                     end
                  end else if (pos_ff == POS_W'(2)) begin
                     rbc_in = b;
                     crc_in = crc_upd;
                     pos_in = pos_ff + POS_W'(1);
                  end else if (pos_ff < data_end) begin
                     crc_in = crc_upd;
                     pos_in = pos_ff + POS_W'(1);
                     if (!pos_off[0]) begin
                        held_in = b;
                     end else begin
                        res.emit               = 1'b1;
                        res.rsp.kind           = mbrh_pkg::KIND_WORD;
                        res.rsp.register_word  = {held_ff, b};
                        res.rsp.register_index = 7'(pos_off >> 1);
                     end
                  end else if (pos_ff == data_end) begin
                     held_in = b;
                     pos_in  = pos_ff + POS_W'(1);
                  end else begin
                     awaiting_in  = 1'b0;
                     res.emit     = 1'b1;
                     res.rsp.kind = mbrh_pkg::KIND_STATUS;
                     if (raddr_ff != target_ff || rfunc_ff != mbrh_pkg::FC_READ
                         || rbc_ff != 8'(2 * int'(count_ff))) begin
                        res.rsp.status = mbrh_pkg::ST_MALFORMED;
                     end else if (got_crc != crc_ff) begin
                        res.rsp.status = mbrh_pkg::ST_CRC_ERROR;
                     end else begin
                        res.rsp.status = mbrh_pkg::ST_OK;
                     end
                  end
               end
            end
            mbrh_pkg::FUNC_TICK: begin
               if (awaiting_ff) begin
                  if (ticks_ff > 16'd1) begin
                     ticks_in = ticks_ff - 16'd1;
                  end else begin
                     ticks_in     = 16'd0;
                     awaiting_in  = 1'b0;
                     res.emit     = 1'b1;
                     res.rsp.kind = mbrh_pkg::KIND_STATUS;
                     res.rsp.status = (pos_ff == '0) ? mbrh_pkg::ST_NO_RESPONSE
                                                     : mbrh_pkg::ST_SHORT_FRAME;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (res.rsp.kind == mbrh_pkg::KIND_STATUS) begin
         res.rsp.exception_code = exc_in;
         res.rsp.last           = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= mbrh_pkg::TIMEOUT_RESET;
         awaiting_ff <= 1'b0;
         exc_ff      <= 8'h00;
         pos_ff      <= '0;
         count_ff    <= '0;
         ticks_ff    <= 16'd0;
      end else begin
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         awaiting_ff <= awaiting_in;
         exc_ff      <= exc_in;
         pos_ff      <= pos_in;
         count_ff    <= count_in;
         ticks_ff    <= ticks_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff <= target_in;
      crc_ff    <= crc_in;
      raddr_ff  <= raddr_in;
      rfunc_ff  <= rfunc_in;
      rbc_ff    <= rbc_in;
      held_ff   <= held_in;
   end

`ifndef SYNTHESIS
   // register words never index past the requested count
   a_word_index: assert property (@(posedge clock) disable iff (reset)
      res.emit && res.rsp.kind == mbrh_pkg::KIND_WORD
      |-> res.rsp.register_index < 7'(count_ff))
      else $error("register word index out of range");
`endif

endmodule
